/* hw/rtl/rotary_encoder_button_decoder_unit_assert.svh */
// Assertion shorthands shared by the decoder modules.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ROTARY_ENCODER_BUTTON_DECODER_UNIT_ASSERT_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define REBD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rebd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define REBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rebd assertion failed");

`endif

/* hw/rtl/rebd_pkg.sv */
package rebd_pkg;

	localparam int TIME_W = 32;
	localparam int CNT_W  = 16;
	localparam int CFG_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_START_PRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX   = 2'd3;

	localparam logic [CFG_W-1:0] START_PRESS_RST = 16'd10;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd1000;
	localparam logic [CFG_W-1:0] SHORT_MIN_RST   = 16'd20;
	localparam logic [CFG_W-1:0] SHORT_MAX_RST   = 16'd250;

	// Result queue; depth must be a power of two.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		EV_PLUS  = 3'd0,
		EV_MINUS = 3'd1,
		EV_START = 3'd2,
		EV_LONG  = 3'd3,
		EV_SHORT = 3'd4
	} event_kind_t;

	typedef struct packed {
		logic              clock_level;
		logic              data_level;
		logic              button_level;
		logic [TIME_W-1:0] now_time;
	} poll_t;

	typedef struct packed {
		event_kind_t kind;
		logic        held;
		logic        last;
	} result_t;

	// Up to two results produced by one poll, in delivery order.
	typedef struct packed {
		logic [1:0] n;
		result_t    ev0;
		result_t    ev1;
	} res_pair_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

endpackage

/* hw/rtl/rebd_poll_if.sv */
interface rebd_poll_if import rebd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              clock_level;
	logic              data_level;
	logic              button_level;
	logic [TIME_W-1:0] now_time;

	modport source (output valid, clock_level, data_level, button_level, now_time,
		input ready);
	modport sink (input valid, clock_level, data_level, button_level, now_time,
		output ready);
endinterface

/* hw/rtl/rebd_event_if.sv */
interface rebd_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic       held_flag;
	logic       last_of_run;

	modport source (output valid, event_kind, held_flag, last_of_run, input ready);
	modport sink (input valid, event_kind, held_flag, last_of_run, output ready);
endinterface

/* hw/rtl/rebd_core.sv */
`include "rotary_encoder_button_decoder_unit_assert.svh"

module rebd_core import rebd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  poll_t     in_poll,
	output logic      in_ready,
	input  cfg_wr_t   cfg,
	input  logic      room,
	output res_pair_t res
);

	logic              valid_s1;
	poll_t             poll_s1;
	logic              prev_clk_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] last_time_q;
	logic [CFG_W-1:0]  start_q;
	logic [CFG_W-1:0]  long_q;
	logic [CFG_W-1:0]  smin_q;
	logic [CFG_W-1:0]  smax_q;

	logic              fire;
	logic              held;
	logic              time_new;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_d;
	logic              btn_ev;
	event_kind_t       btn_kind;
	logic              step;
	event_kind_t       step_kind;
	logic              ev1_is_step;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	assign held     = !poll_s1.button_level;
	assign time_new = poll_s1.now_time != last_time_q;
	assign cnt_inc  = cnt_q + CNT_W'(1);

	// Button counter and its events; only evaluated on a fresh time stamp.
	always_comb begin
		cnt_d    = cnt_q;
		btn_ev   = 1'b0;
		btn_kind = EV_START;
		if (time_new) begin
			if (held) begin
				if (cnt_q != CNT_MAX) begin
					cnt_d = cnt_inc;
					if (cnt_inc == long_q) begin
						btn_ev   = 1'b1;
						btn_kind = EV_LONG;
					end else if (cnt_inc == start_q) begin
						btn_ev   = 1'b1;
						btn_kind = EV_START;
					end
				end
			end else begin
				if ((cnt_q > smin_q) && (cnt_q < smax_q)) begin
					btn_ev   = 1'b1;
					btn_kind = EV_SHORT;
				end
				cnt_d = '0;
			end
		end
	end

	// Any edge on the clock line is a step; equal clock and data levels mean minus.
	assign step      = poll_s1.clock_level != prev_clk_q;
	assign step_kind = (poll_s1.clock_level ^ poll_s1.data_level) ? EV_PLUS : EV_MINUS;

	always_comb begin
		res          = '0;
		res.ev0.kind = EV_PLUS;
		res.ev1.kind = EV_PLUS;
		if (fire) begin
			if (btn_ev) begin
				res.ev0.kind = btn_kind;
				res.ev0.held = 1'b0;
				res.ev0.last = !step;
				res.ev1.kind = step_kind;
				res.ev1.held = held;
				res.ev1.last = 1'b1;
				res.n        = step ? 2'd2 : 2'd1;
			end else if (step) begin
				res.ev0.kind = step_kind;
				res.ev0.held = held;
				res.ev0.last = 1'b1;
				res.n        = 2'd1;
			end
		end
	end

	assign ev1_is_step = (res.ev1.kind == EV_PLUS) || (res.ev1.kind == EV_MINUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			poll_s1 <= in_poll;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_clk_q  <= 1'b0;
			cnt_q       <= '0;
			last_time_q <= '0;
		end else if (fire) begin
			prev_clk_q <= poll_s1.clock_level;
			cnt_q      <= cnt_d;
			if (time_new) begin
				last_time_q <= poll_s1.now_time;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_PRESS_RST;
			long_q  <= LONG_PRESS_RST;
			smin_q  <= SHORT_MIN_RST;
			smax_q  <= SHORT_MAX_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				CFG_START_PRESS: start_q <= cfg.data;
				CFG_LONG_PRESS:  long_q  <= cfg.data;
				CFG_SHORT_MIN:   smin_q  <= cfg.data;
				CFG_SHORT_MAX:   smax_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// A saturated counter stays saturated while the button is still held.
	`REBD_ASSERT_NEXT(a_cnt_sat, fire && held && cnt_q == CNT_MAX, cnt_q == CNT_MAX)
	// Two results only come from a fresh time stamp together with a step.
	`REBD_ASSERT_SAME(a_pair_src, res.n == 2'd2, time_new && step && fire)
	// The second result of a pair is always a step and closes the run.
	`REBD_ASSERT_SAME(a_pair_tail, res.n == 2'd2, res.ev1.last && !res.ev0.last && ev1_is_step)

endmodule

/* hw/rtl/rebd_res_fifo.sv */
`include "rotary_encoder_button_decoder_unit_assert.svh"

module rebd_res_fifo import rebd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t push,
	output logic      room,
	output logic      head_valid,
	output result_t   head,
	input  logic      pop
);

	result_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;
	logic [FIFO_PTR_W-1:0]  wr_ptr_nx;

	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign wr_ptr_nx  = wr_ptr_q + FIFO_PTR_W'(1);

	// Room for a full pair, counting the beat that leaves this cycle.
	assign room = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2)) ||
		(pop && (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 1)));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.ev0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
		end
	end

	`REBD_ASSERT_SAME(a_no_overflow, push.n != 2'd0, room)
	`REBD_ASSERT_SAME(a_count_bound, 1'b1, count_q <= FIFO_CNT_W'(FIFO_DEPTH))
	`REBD_ASSERT_SAME(a_pop_valid, pop, head_valid)

endmodule

/* hw/rtl/rotary_encoder_button_decoder_unit.sv */
// Rotary encoder and push-button decoder.
// The poll channel takes one beat per sample of the encoder clock (A) and data (B)
// lines, the active-low button line and a 32-bit time stamp. The event channel gives
// one beat per event: a plus or minus step tagged with the button state, or a start,
// long or short press. A poll yields zero, one or two beats; the button event comes
// first and last_of_run marks the final beat of each poll.
// Polls pass the input stage, then the result queue. A poll is accepted every cycle as
// long as the four-entry result queue can hold two more beats, so the sustained rate is
// one poll per cycle whenever the event side keeps up; a poll giving two events needs
// two event beats to drain. The four threshold registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is idle, which
// the block does not enforce. Reset restores the thresholds to 10, 1000, 20 and 250,
// and clears the press counter, the stored time stamp, the clock history and the queue.
// When the receiver stalls, queued events wait in order; once the queue cannot take a
// further pair, poll.ready falls and the poll held in the input stage waits with it.
module rotary_encoder_button_decoder_unit import rebd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	rebd_poll_if.sink            poll,
	rebd_event_if.source         events,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	poll_t     in_poll;
	cfg_wr_t   cfg;
	res_pair_t res;
	result_t   head;
	logic      room;
	logic      head_valid;
	logic      pop;

	assign in_poll.clock_level  = poll.clock_level;
	assign in_poll.data_level   = poll.data_level;
	assign in_poll.button_level = poll.button_level;
	assign in_poll.now_time     = poll.now_time;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Input stage, counter state and event selection.
	rebd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (poll.valid),
		.in_poll  (in_poll),
		.in_ready (poll.ready),
		.cfg      (cfg),
		.room     (room),
		.res      (res)
	);

	// Small queue so that a pair of events can be handed over together
	// and drained one beat at a time.
	rebd_res_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	assign pop                = head_valid && events.ready;
	assign events.valid       = head_valid;
	assign events.event_kind  = head.kind;
	assign events.held_flag   = head.held;
	assign events.last_of_run = head.last;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

// Poll-by-poll check of the rotary encoder and push-button decoder.
// Polls are queued up front by the stimulus process and offered by a clocked driver.
// Each accepted poll is decoded by a local model, which leaves the event beats that
// poll should cause in a queue. A clocked monitor pops that queue on every accepted
// event beat and compares kind, held flag and last-of-run marker.
module tb_top import rebd_pkg::*; ();

	// Generous ceiling on the length of a run.
	localparam int CYCLE_LIMIT = 1_000_000;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	rebd_poll_if  poll_bus ();
	rebd_event_if event_bus ();

	rotary_encoder_button_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_bus),
		.events    (event_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Polls waiting to be offered, and event beats still owed by the block.
	poll_t   polls_waiting [$];
	result_t events_due [$];
	int      polls_queued = 0;

	// Idle rates (per cent) and a long receiver hold-off, all set by the stimulus
	// process on the falling edge so that the clocked processes never race with it.
	int send_gap_pct   = 14;
	int recv_stall_pct = 45;
	int rx_hold        = 0;

	bit failed = 1'b0;
	int cycle_count = 0;

	// Local copy of the decoder state and thresholds, both as they are after reset.
	logic [CFG_W-1:0]  thr_start = START_PRESS_RST;
	logic [CFG_W-1:0]  thr_long  = LONG_PRESS_RST;
	logic [CFG_W-1:0]  thr_min   = SHORT_MIN_RST;
	logic [CFG_W-1:0]  thr_max   = SHORT_MAX_RST;
	logic              model_prev_clk  = 1'b0;
	logic [CNT_W-1:0]  model_count     = '0;
	logic [TIME_W-1:0] model_last_time = '0;

	// Stimulus generator's running view of the encoder clock line and the time stamp.
	logic [TIME_W-1:0] gen_time = '0;
	bit                gen_clk  = 1'b0;

	poll_t   next_poll;
	result_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Decodes one accepted poll and queues the event beats it must produce: the button
	// event first, the encoder step second, with the marker on the final one.
	function automatic void decode_poll(input poll_t p);
		result_t due [$];
		result_t r;
		bit      held;
		r = '0;
		held = !p.button_level;
		// The button is only looked at when the time stamp has moved on.
		if (p.now_time != model_last_time) begin
			if (held) begin
				// A saturated counter no longer advances, so no event can fire again.
				if (model_count != CNT_MAX) begin
					model_count = model_count + 1'b1;
					// Long press wins when both thresholds are equal.
					if (model_count == thr_long) begin
						r.kind = EV_LONG;
						due = {due, r};
					end else if (model_count == thr_start) begin
						r.kind = EV_START;
						due = {due, r};
					end
				end
			end else begin
				// Release: a short press only when the count lies strictly inside.
				if (model_count > thr_min && model_count < thr_max) begin
					r.kind = EV_SHORT;
					due = {due, r};
				end
				model_count = '0;
			end
			model_last_time = p.now_time;
		end
		// Any edge on the encoder clock line is a step; equal levels mean minus.
		if (p.clock_level != model_prev_clk) begin
			r.kind = (p.clock_level == p.data_level) ? EV_MINUS : EV_PLUS;
			r.held = held;
			due = {due, r};
			model_prev_clk = p.clock_level;
		end
		if (due.size() != 0)
			due[due.size() - 1].last = 1'b1;
		foreach (due[i])
			events_due = {events_due, due[i]};
	endfunction

	// Poll driver. A beat stays on the bus until it is taken; a new beat, or a gap,
	// is only chosen once the bus is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_bus.valid <= 1'b0;
		end else begin
			if (poll_bus.valid && poll_bus.ready) begin
				next_poll.clock_level  = poll_bus.clock_level;
				next_poll.data_level   = poll_bus.data_level;
				next_poll.button_level = poll_bus.button_level;
				next_poll.now_time     = poll_bus.now_time;
				decode_poll(next_poll);
			end
			if (!poll_bus.valid || poll_bus.ready) begin
				if (polls_waiting.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_poll = polls_waiting.pop_front();
					poll_bus.valid        <= 1'b1;
					poll_bus.clock_level  <= next_poll.clock_level;
					poll_bus.data_level   <= next_poll.data_level;
					poll_bus.button_level <= next_poll.button_level;
					poll_bus.now_time     <= next_poll.now_time;
				end else begin
					poll_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Counts down the long receiver hold-off by one on every rising edge.
	always @(posedge clk) begin
		if (rx_hold > 0)
			rx_hold <= rx_hold - 1;
	end

	// Event monitor. It checks each accepted beat against the oldest owed beat and
	// drives ready, kept low throughout the hold-off so that the result queue fills up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_bus.ready <= 1'b0;
		end else begin
			if (event_bus.valid && event_bus.ready) begin
				if (events_due.size() == 0) begin
					$display("%0t: event beat with nothing owed: kind %0d held %0b last %0b",
						$time, event_bus.event_kind, event_bus.held_flag,
						event_bus.last_of_run);
					failed = 1'b1;
				end else begin
					want = events_due.pop_front();
					if (event_bus.event_kind !== want.kind || event_bus.held_flag !== want.held
							|| event_bus.last_of_run !== want.last) begin
						$display("%0t: expected kind %0d held %0b last %0b, got %0d %0b %0b",
							$time, want.kind, want.held, want.last, event_bus.event_kind,
							event_bus.held_flag, event_bus.last_of_run);
						failed = 1'b1;
					end
				end
			end
			if (rx_hold > 0) begin
				event_bus.ready <= 1'b0;
			end else begin
				event_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic queue_poll(input bit c, input bit d, input bit b, input logic [TIME_W-1:0] t);
		poll_t p;
		p.clock_level  = c;
		p.data_level   = d;
		p.button_level = b;
		p.now_time     = t;
		polls_waiting = {polls_waiting, p};
		polls_queued++;
	endtask

	// Writes all four thresholds on consecutive edges and mirrors them in the model.
	task automatic write_thresholds(input logic [CFG_W-1:0] s, l, mn, mx);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_PRESS;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= CFG_LONG_PRESS;
		cfg_data  <= l;
		@(posedge clk);
		cfg_index <= CFG_SHORT_MIN;
		cfg_data  <= mn;
		@(posedge clk);
		cfg_index <= CFG_SHORT_MAX;
		cfg_data  <= mx;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_start = s;
		thr_long  = l;
		thr_min   = mn;
		thr_max   = mx;
	endtask

	// Waits until every poll has gone in and every owed beat has come out, then goes on
	// waiting, since a poll with no events may still be in flight.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (polls_waiting.size() != 0 || poll_bus.valid || events_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Mostly whole presses whose lengths sit around the current thresholds, with
	// repeated time stamps and encoder turns mixed in; the rest is random noise.
	task automatic queue_random(input int count);
		int target;
		int len;
		int steps;
		target = polls_queued + count;
		while (polls_queued < target) begin
			if ($urandom_range(99) < 15) begin
				case ($urandom_range(3))
					0, 1: gen_time = $urandom;
					2: gen_time = gen_time + 1'b1;
					default: ;
				endcase
				gen_clk = 1'($urandom_range(1));
				queue_poll(gen_clk, 1'($urandom_range(1)), 1'($urandom_range(1)), gen_time);
			end else begin
				case ($urandom_range(4))
					0: len = int'(thr_start) + int'($urandom_range(2)) - 1;
					1: len = int'(thr_long) + int'($urandom_range(2)) - 1;
					2: len = int'(thr_min) + int'($urandom_range(2)) - 1;
					3: len = int'(thr_max) + int'($urandom_range(2)) - 1;
					default: len = int'($urandom_range(1, 12));
				endcase
				if (len < 1)
					len = 1;
				if (len > 300)
					len = int'($urandom_range(1, 300));
				steps = 0;
				while (steps < len) begin
					if ($urandom_range(7) != 0) begin
						gen_time = gen_time + $urandom_range(1, 3);
						steps++;
					end
					if ($urandom_range(2) == 0)
						gen_clk = ~gen_clk;
					queue_poll(gen_clk, 1'($urandom_range(1)), 1'b0, gen_time);
				end
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(3) != 0)
						gen_time = gen_time + 1'b1;
					if ($urandom_range(2) == 0)
						gen_clk = ~gen_clk;
					queue_poll(gen_clk, 1'($urandom_range(1)), 1'b1, gen_time);
				end
			end
		end
	endtask

	// One threshold setting: the receiver first holds off for a long stretch while
	// polls keep coming, then half way through the sender waits for a full drain.
	task automatic run_phase(input logic [CFG_W-1:0] s, l, mn, mx, input int gap, stall,
			input int count);
		write_thresholds(s, l, mn, mx);
		@(negedge clk);
		send_gap_pct   = gap;
		recv_stall_pct = stall;
		rx_hold        = 150 + int'($urandom_range(150));
		queue_random(count / 2);
		wait_drained();
		@(negedge clk);
		queue_random(count - count / 2);
		wait_drained();
	endtask

	initial begin
		arst_n                 = 1'b0;
		poll_bus.valid         = 1'b0;
		poll_bus.clock_level   = 1'b0;
		poll_bus.data_level    = 1'b0;
		poll_bus.button_level  = 1'b1;
		poll_bus.now_time      = '0;
		event_bus.ready        = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_START_PRESS;
		cfg_data               = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset thresholds: a first poll carrying the reset time stamp is not
		// evaluated, yet an encoder edge still gives a step tagged as held.
		@(negedge clk);
		queue_poll(1'b0, 1'b0, 1'b1, 32'h0);
		queue_poll(1'b1, 1'b0, 1'b0, 32'h0);
		queue_poll(1'b1, 1'b1, 1'b0, 32'h0);
		wait_drained();

		// Small thresholds so that every event kind shows up within a few polls.
		write_thresholds(16'd2, 16'd4, 16'd1, 16'd4);
		@(negedge clk);
		queue_poll(1'b0, 1'b1, 1'b0, 32'd5);
		queue_poll(1'b0, 1'b0, 1'b0, 32'd5);
		queue_poll(1'b1, 1'b1, 1'b0, 32'd6);
		queue_poll(1'b1, 1'b1, 1'b1, 32'd7);
		for (int t = 8; t <= 12; t++)
			queue_poll(1'b1, 1'b0, 1'b0, 32'(t));
		queue_poll(1'b0, 1'b0, 1'b1, 32'd13);
		// Time stamp wrap in the middle of a press, released at the window's lower edge.
		queue_poll(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		queue_poll(1'b0, 1'b1, 1'b1, 32'h0);
		queue_poll(1'b1, 1'b0, 1'b0, 32'd1);
		queue_poll(1'b1, 1'b0, 1'b0, 32'd2);
		queue_poll(1'b1, 1'b1, 1'b0, 32'd3);
		queue_poll(1'b0, 1'b1, 1'b1, 32'd4);
		wait_drained();
		gen_time = 32'd4;
		gen_clk  = 1'b0;

		run_phase(16'd3, 16'd9, 16'd2, 16'd7, 14, 45, 400);
		// Equal start and long counts, widest short window.
		run_phase(16'd4, 16'd4, 16'd0, 16'hFFFF, 45, 14, 400);
		// Start count of zero and a window too narrow to hold any count.
		run_phase(16'd0, 16'd6, 16'd5, 16'd6, 0, 0, 250);
		run_phase(16'd1, 16'd2, 16'd0, 16'd3, 0, 0, 200);

		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
